/* sv/cdf_pkg.sv */
package cdf_pkg;

	localparam logic [7:0] START_MARK = 8'hAA;
	localparam logic [7:0] END_MARK   = 8'h55;
	localparam logic [1:0] TYPE_MARK  = 2'b11;
	localparam logic [3:0] MAX_DLC    = 4'd8;
	localparam logic [3:0] ID_LEN_EXT = 4'd4;
	localparam logic [3:0] ID_LEN_STD = 4'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_TYPE = 2'd1;
	localparam logic [1:0] ST_BAD_DLC  = 2'd2;
	localparam logic [1:0] ST_BAD_END  = 2'd3;

	typedef enum logic [2:0] {
		OP_START,
		OP_ID,
		OP_DATA,
		OP_DONE,
		OP_ERR
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  rx_byte;
		logic [2:0]  pos;
		logic [1:0]  status;
	} cmd_t;

endpackage

/* sv/cdf_front.sv */
module cdf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	output logic          push,
	output cdf_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		HUNT,
		TYPE_BYTE,
		BODY,
		END_BYTE
	} phase_t;

	phase_t     phase_q;
	logic [3:0] bytes_left_q;
	logic [3:0] body_index_q;
	logic       ext_q;

	logic [3:0] id_len;
	logic [3:0] type_id_len;
	logic [3:0] data_off;
	logic       type_ok;
	logic       dlc_ok;

	assign id_len      = ext_q ? cdf_pkg::ID_LEN_EXT : cdf_pkg::ID_LEN_STD;
	assign type_id_len = rx_byte[5] ? cdf_pkg::ID_LEN_EXT : cdf_pkg::ID_LEN_STD;
	assign data_off    = body_index_q - id_len;
	assign type_ok     = rx_byte[7:6] == cdf_pkg::TYPE_MARK;
	assign dlc_ok      = rx_byte[3:0] <= cdf_pkg::MAX_DLC;

	always_comb begin
		push        = 1'b0;
		cmd.op      = cdf_pkg::OP_START;
		cmd.rx_byte = rx_byte;
		cmd.pos     = '0;
		cmd.status  = cdf_pkg::ST_OK;
		unique case (phase_q)
			HUNT: begin
				push = 1'b0;
			end
			TYPE_BYTE: begin
				push = accept;
				if (!type_ok) begin
					cmd.op     = cdf_pkg::OP_ERR;
					cmd.status = cdf_pkg::ST_BAD_TYPE;
				end else if (!dlc_ok) begin
					cmd.op     = cdf_pkg::OP_ERR;
					cmd.status = cdf_pkg::ST_BAD_DLC;
				end
			end
			BODY: begin
				push = accept;
				if (body_index_q < id_len) begin
					cmd.op  = cdf_pkg::OP_ID;
					cmd.pos = body_index_q[2:0];
				end else begin
					cmd.op  = cdf_pkg::OP_DATA;
					cmd.pos = data_off[2:0];
				end
			end
			END_BYTE: begin
				push = accept;
				if (rx_byte == cdf_pkg::END_MARK) begin
					cmd.op = cdf_pkg::OP_DONE;
				end else begin
					cmd.op     = cdf_pkg::OP_ERR;
					cmd.status = cdf_pkg::ST_BAD_END;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= HUNT;
			bytes_left_q <= '0;
			body_index_q <= '0;
			ext_q        <= 1'b0;
		end else if (accept) begin
			unique case (phase_q)
				HUNT: begin
					if (rx_byte == cdf_pkg::START_MARK) begin
						phase_q <= TYPE_BYTE;
					end
				end
				TYPE_BYTE: begin
					if (type_ok && dlc_ok) begin
						phase_q      <= BODY;
						ext_q        <= rx_byte[5];
						body_index_q <= '0;
						bytes_left_q <= type_id_len + (rx_byte[4] ? 4'd0 : rx_byte[3:0]);
					end else begin
						phase_q <= HUNT;
					end
				end
				BODY: begin
					body_index_q <= body_index_q + 4'd1;
					bytes_left_q <= bytes_left_q - 4'd1;
					if (bytes_left_q <= 4'd1) begin
						phase_q <= END_BYTE;
					end
				end
				END_BYTE: begin
					phase_q <= HUNT;
				end
				default: begin
					phase_q <= HUNT;
				end
			endcase
		end
	end

endmodule

/* sv/cdf_queue.sv */
module cdf_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cdf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output cdf_pkg::cmd_t pop_cmd
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cdf_pkg::cmd_t  entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = count_q == CW'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pop_valid |-> !pop) else $error("pop from empty queue");
`endif

endmodule

/* sv/cdf_back.sv */
module cdf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  cdf_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic          is_extended,
	output logic          is_remote,
	output logic [3:0]    length_code,
	output logic [28:0]   can_id,
	output logic [63:0]   payload
);

	logic        ext_q;
	logic        rtr_q;
	logic [3:0]  dlc_q;
	logic [28:0] id_q;
	logic [63:0] data_q;
	logic        out_valid_q;
	logic        is_emit;
	logic        out_free;

	assign is_emit  = cmd.op == cdf_pkg::OP_DONE || cmd.op == cdf_pkg::OP_ERR;
	assign out_free = !out_valid_q || !out_stall;
	assign cmd_pop  = cmd_valid && (!is_emit || out_free);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			unique case (cmd.op)
				cdf_pkg::OP_START: begin
					ext_q  <= cmd.rx_byte[5];
					rtr_q  <= cmd.rx_byte[4];
					dlc_q  <= cmd.rx_byte[3:0];
					id_q   <= '0;
					data_q <= '0;
				end
				cdf_pkg::OP_ID: begin
					case (cmd.pos[1:0])
						2'd0: id_q[7:0]   <= cmd.rx_byte;
						2'd1: id_q[15:8]  <= cmd.rx_byte;
						2'd2: id_q[23:16] <= cmd.rx_byte;
						default: id_q[28:24] <= cmd.rx_byte[4:0];
					endcase
				end
				cdf_pkg::OP_DATA: begin
					data_q[{cmd.pos, 3'b000} +: 8] <= cmd.rx_byte;
				end
				cdf_pkg::OP_DONE: begin
					status      <= cdf_pkg::ST_OK;
					is_extended <= ext_q;
					is_remote   <= rtr_q;
					length_code <= dlc_q;
					can_id      <= ext_q ? id_q : {18'd0, id_q[10:0]};
					payload     <= rtr_q ? 64'd0 : data_q;
				end
				cdf_pkg::OP_ERR: begin
					status      <= cmd.status;
					is_extended <= 1'b0;
					is_remote   <= 1'b0;
					length_code <= '0;
					can_id      <= '0;
					payload     <= '0;
				end
				default: begin
					id_q <= id_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop && is_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != cdf_pkg::ST_OK |-> can_id == '0 && payload == '0
		&& !is_extended && !is_remote && length_code == '0)
		else $error("error item carries frame fields");
	a_remote_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_remote |-> payload == '0) else $error("remote item has payload");
	a_std_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_extended |-> can_id[28:11] == '0) else $error("standard id too wide");
	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && is_emit |-> out_free) else $error("result overwritten");
`endif

endmodule

/* sv/can_serial_frame_deframer.sv */
// Result path: the command for the end marker, or for the byte that fails the frame, is written
// into the command queue, then popped into the registered result on out_valid once the output is free.
// Throughput: one byte per cycle; the front end runs on its own and a small command queue
// absorbs output stalls, so rx_byte stalls only when that queue is full.
// Reset (arst_n low): phase returns to hunting, queue empties, out_valid drops.
module can_serial_frame_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        is_extended,
	output logic        is_remote,
	output logic [3:0]  length_code,
	output logic [28:0] can_id,
	output logic [63:0] payload
);

	logic          accept;
	logic          push;
	logic          full;
	logic          pop;
	logic          pop_valid;
	cdf_pkg::cmd_t push_cmd;
	cdf_pkg::cmd_t pop_cmd;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	cdf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.push    (push),
		.cmd     (push_cmd)
	);

	cdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	cdf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (pop_valid),
		.cmd         (pop_cmd),
		.cmd_pop     (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.is_extended (is_extended),
		.is_remote   (is_remote),
		.length_code (length_code),
		.can_id      (can_id),
		.payload     (payload)
	);

endmodule

/* dv/tb_can_serial_frame_deframer.sv */
`timescale 1ns / 100ps

module tb_can_serial_frame_deframer;

	localparam int RANDOM_ITEMS = 750;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 2000;
	localparam logic [28:0] ID_STD_MASK = 29'h7FF;

	typedef enum logic [1:0] {
		P_HUNT,
		P_TYPE,
		P_BODY,
		P_TAIL
	} deframe_phase_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        ext;
		logic        rtr;
		logic [3:0]  dlc;
		logic [28:0] id;
		logic [63:0] data;
	} can_frame_t;

	typedef struct packed {
		logic [7:0] b;
		logic       pinned;
		can_frame_t want;
	} stim_row_t;

	localparam can_frame_t NO_FRAME = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        is_extended;
	logic        is_remote;
	logic [3:0]  length_code;
	logic [28:0] can_id;
	logic [63:0] payload;

	can_serial_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.is_extended(is_extended),
		.is_remote(is_remote),
		.length_code(length_code),
		.can_id(can_id),
		.payload(payload)
	);

	always #5 clk = ~clk;

	// predictor state
	deframe_phase_t frame_phase = P_HUNT;
	logic [3:0]  frame_left = '0;
	logic [3:0]  frame_idx = '0;
	logic        frame_ext = 1'b0;
	logic        frame_rtr = 1'b0;
	logic [3:0]  frame_dlc = '0;
	logic [28:0] id_acc = '0;
	logic [63:0] data_acc = '0;

	can_frame_t pending_frames[$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int tx_pcts[3] = '{25, 86, 0};
	int rx_pcts[3] = '{86, 25, 0};
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int useful_items = 0;
	int bytes_sent = 0;
	int mismatches = 0;
	int frames_ok = 0;
	int frames_bad[4] = '{0, 0, 0, 0};

	stim_row_t directed_rows [25] = '{
		'{8'h00, 1'b0, NO_FRAME},
		'{8'hAA, 1'b0, NO_FRAME},
		'{8'hAA, 1'b1, '{cdf_pkg::ST_BAD_TYPE, 1'b0, 1'b0, 4'd0, 29'd0, 64'd0}},
		'{8'hAA, 1'b0, NO_FRAME},
		'{8'hC9, 1'b1, '{cdf_pkg::ST_BAD_DLC, 1'b0, 1'b0, 4'd0, 29'd0, 64'd0}},
		'{8'hAA, 1'b0, NO_FRAME},
		'{8'hC8, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, NO_FRAME},
		'{8'h00, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, NO_FRAME},
		'{8'hAA, 1'b0, NO_FRAME},
		'{8'h55, 1'b0, NO_FRAME},
		'{8'h01, 1'b0, NO_FRAME},
		'{8'h80, 1'b0, NO_FRAME},
		'{8'h7F, 1'b0, NO_FRAME},
		'{8'hFE, 1'b0, NO_FRAME},
		'{8'h55, 1'b1, '{cdf_pkg::ST_OK, 1'b0, 1'b0, 4'd8, 29'h7FF,
			64'hFE7F_8001_55AA_FF00}},
		'{8'hAA, 1'b0, NO_FRAME},
		'{8'hF8, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, NO_FRAME},
		'{8'h00, 1'b1, '{cdf_pkg::ST_BAD_END, 1'b0, 1'b0, 4'd0, 29'd0, 64'd0}}
	};

	function automatic void deframe_byte(input logic [7:0] b, output bit got,
			output can_frame_t r);
		logic [3:0] id_len;
		got = 1'b0;
		r = NO_FRAME;
		id_len = frame_ext ? cdf_pkg::ID_LEN_EXT : cdf_pkg::ID_LEN_STD;
		case (frame_phase)
			P_HUNT: begin
				if (b == cdf_pkg::START_MARK)
					frame_phase = P_TYPE;
			end
			P_TYPE: begin
				if (b[7:6] != cdf_pkg::TYPE_MARK) begin
					got = 1'b1;
					r.status = cdf_pkg::ST_BAD_TYPE;
					frame_phase = P_HUNT;
				end else begin
					frame_ext = b[5];
					frame_rtr = b[4];
					frame_dlc = b[3:0];
					if (frame_dlc > cdf_pkg::MAX_DLC) begin
						got = 1'b1;
						r.status = cdf_pkg::ST_BAD_DLC;
						frame_phase = P_HUNT;
					end else begin
						frame_left = (frame_ext ? cdf_pkg::ID_LEN_EXT : cdf_pkg::ID_LEN_STD) +
							(frame_rtr ? 4'd0 : frame_dlc);
						frame_idx = '0;
						id_acc = '0;
						data_acc = '0;
						frame_phase = P_BODY;
					end
				end
			end
			P_BODY: begin
				if (frame_idx < id_len)
					id_acc = id_acc | (29'(b) << (8 * frame_idx));
				else
					data_acc = data_acc | (64'(b) << (8 * ((frame_idx - id_len) & 4'd7)));
				frame_idx = frame_idx + 4'd1;
				if (frame_left != 0)
					frame_left = frame_left - 4'd1;
				if (frame_left == 0)
					frame_phase = P_TAIL;
			end
			default: begin
				got = 1'b1;
				frame_phase = P_HUNT;
				if (b != cdf_pkg::END_MARK)
					r.status = cdf_pkg::ST_BAD_END;
				else
					r = '{cdf_pkg::ST_OK, frame_ext, frame_rtr, frame_dlc,
						frame_ext ? id_acc : (id_acc & ID_STD_MASK),
						frame_rtr ? 64'd0 : data_acc};
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic pinned, input can_frame_t want);
		bit got;
		can_frame_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		if (frame_phase != P_HUNT || b == cdf_pkg::START_MARK)
			useful_items++;
		bytes_sent++;
		deframe_byte(b, got, r);
		if (pinned)
			pending_frames.insert(pending_frames.size(), want);
		else if (got)
			pending_frames.insert(pending_frames.size(), r);
	endtask

	// mostly well-formed frames; some bad type, bad dlc, bad end, and line noise
	task automatic send_random_frame();
		int kind;
		int n;
		logic ext;
		logic rtr;
		logic [3:0] dlc;
		logic [1:0] top;
		logic [7:0] b;
		logic [7:0] seq[$];
		kind = $urandom_range(99);
		ext = 1'($urandom_range(1));
		rtr = ($urandom_range(3) == 0);
		dlc = 4'($urandom_range(8));
		if (kind >= 92) begin
			n = $urandom_range(1, 4);
			repeat (n) seq.insert(seq.size(), 8'($urandom));
		end else begin
			seq.insert(seq.size(), cdf_pkg::START_MARK);
			if (kind >= 85) begin
				top = 2'($urandom_range(2));
				seq.insert(seq.size(), {top, 6'($urandom)});
			end else if (kind >= 78) begin
				seq.insert(seq.size(), {cdf_pkg::TYPE_MARK, ext, rtr,
					4'($urandom_range(9, 15))});
			end else begin
				seq.insert(seq.size(), {cdf_pkg::TYPE_MARK, ext, rtr, dlc});
				n = (ext ? 4 : 2) + (rtr ? 0 : int'(dlc));
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(7) == 0)
						b = $urandom_range(1) ? cdf_pkg::START_MARK : cdf_pkg::END_MARK;
					else
						b = 8'($urandom);
					seq.insert(seq.size(), b);
				end
				if (kind >= 70) begin
					do b = 8'($urandom); while (b == cdf_pkg::END_MARK);
					seq.insert(seq.size(), b);
				end else begin
					seq.insert(seq.size(), cdf_pkg::END_MARK);
				end
			end
		end
		foreach (seq[i])
			send_byte(seq[i], 1'b0, NO_FRAME);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected 'h%0h got 'h%0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			hold_done <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		can_frame_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result status %0d id 'h%0h", $time, status, can_id);
			end else begin
				want = pending_frames.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("is_extended", 64'(want.ext), 64'(is_extended));
				check_field("is_remote", 64'(want.rtr), 64'(is_remote));
				check_field("length_code", 64'(want.dlc), 64'(length_code));
				check_field("can_id", 64'(want.id), 64'(can_id));
				check_field("payload", want.data, payload);
				if (want.status == cdf_pkg::ST_OK)
					frames_ok++;
				else
					frames_bad[want.status]++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("tb_can_serial_frame_deframer NOT OK");
			$finish;
		end
	end

	initial begin
		int goal;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].pinned, directed_rows[i].want);
		drain();
		for (int p = 0; p < 3; p++) begin
			tx_idle_pct = tx_pcts[p];
			rx_stall_pct = rx_pcts[p];
			if (p == 2)
				hold_req++;
			goal = useful_items + RANDOM_ITEMS / 3;
			while (useful_items < goal)
				send_random_frame();
			drain();
		end
		repeat (16) @(posedge clk);
		$display("bytes sent %0d (%0d inside frames), frames ok %0d", bytes_sent,
			useful_items, frames_ok);
		$display("errors seen: bad type %0d, dlc over 8 %0d, bad end marker %0d",
			frames_bad[cdf_pkg::ST_BAD_TYPE], frames_bad[cdf_pkg::ST_BAD_DLC],
			frames_bad[cdf_pkg::ST_BAD_END]);
		if (mismatches == 0)
			$display("tb_can_serial_frame_deframer OK");
		else
			$display("tb_can_serial_frame_deframer NOT OK");
		$finish;
	end

endmodule
